/* hdl/dehd_pkg.sv */
// ----------------------------------------------------------------------------
// dehd_pkg
// Shared types, constants and helpers for the digitizer event header decoder.
// ----------------------------------------------------------------------------
package dehd_pkg;

    // Event layout
    localparam int HEADER_WORDS    = 13;
    localparam int MAX_TRACE_WORDS = 1024;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int POS_W    = 12;
    localparam int TAG_W    = 5;
    localparam int VALUE_W  = 48;
    localparam int SAMPLE_W = 11;

    // Results one item can cause, and the width of a result count
    localparam int MAX_RESULTS = 5;
    localparam int COUNT_W     = 3;

    // Header types
    localparam logic [3:0] HDR_LED     = 4'd0;
    localparam logic [3:0] HDR_LED_NEW = 4'd1;
    localparam logic [3:0] HDR_CFD     = 4'd2;

    // Result tags
    typedef enum logic [TAG_W-1:0] {
        TAG_CHAN        = 5'd0,
        TAG_BOARD       = 5'd1,
        TAG_ID          = 5'd2,
        TAG_PKT_LEN     = 5'd3,
        TAG_GEO         = 5'd4,
        TAG_HDR_TYPE    = 5'd5,
        TAG_EVT_TYPE    = 5'd6,
        TAG_HDR_LEN     = 5'd7,
        TAG_TIMESTAMP   = 5'd8,
        TAG_FLAGS       = 5'd9,
        TAG_CFD0        = 5'd10,
        TAG_CFD1        = 5'd11,
        TAG_CFD2        = 5'd12,
        TAG_LAST_DISC   = 5'd13,
        TAG_SAMPLED_BL  = 5'd14,
        TAG_PRE_ENERGY  = 5'd15,
        TAG_POST_ENERGY = 5'd16,
        TAG_PEAK_TS     = 5'd17,
        TAG_M1_BEGIN    = 5'd18,
        TAG_M1_END      = 5'd19,
        TAG_M2_BEGIN    = 5'd20,
        TAG_M2_END      = 5'd21,
        TAG_PEAK_SAMPLE = 5'd22,
        TAG_BASE_SAMPLE = 5'd23,
        TAG_BASELINE    = 5'd24,
        TAG_TRACE       = 5'd25,
        TAG_END         = 5'd26
    } tag_t;

    // One result
    typedef struct packed {
        tag_t                tag;
        logic [VALUE_W-1:0]  value;
        logic [SAMPLE_W-1:0] pos;
    } entry_t;

    // All results of one item
    typedef struct packed {
        entry_t [MAX_RESULTS-1:0] ent;
        logic   [COUNT_W-1:0]     count;
    } run_t;

    function automatic entry_t mk_entry(tag_t tag, logic [VALUE_W-1:0] value,
                                        logic [SAMPLE_W-1:0] pos);
        entry_t e;
        e.tag   = tag;
        e.value = value;
        e.pos   = pos;
        return e;
    endfunction

    // Flag bits kept for each header type
    function automatic logic [15:0] flag_mask(logic [3:0] kind);
        logic [15:0] m;
        case (kind)
            HDR_LED:     m = 16'hB600;
            HDR_LED_NEW: m = 16'hF700;
            HDR_CFD:     m = 16'hFF80;
            default:     m = 16'h0000;
        endcase
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] swap_bytes(logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* hdl/dehd_decode.sv */
// ----------------------------------------------------------------------------
// dehd_decode
// Decodes one registered event word into its list of results and keeps the
// per-event state (word position, header type, partial fields, held trace).
// ----------------------------------------------------------------------------
module dehd_decode (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [dehd_pkg::WORD_W-1:0] raw_word,
    input  logic                       eoe,
    output dehd_pkg::run_t             run
);
    import dehd_pkg::*;

    localparam logic [POS_W-1:0] HDR_WORDS = POS_W'(HEADER_WORDS);
    localparam logic [POS_W-1:0] TRACE_END = POS_W'(HEADER_WORDS + MAX_TRACE_WORDS);
    localparam logic [POS_W-1:0] MAX_TRACE = POS_W'(MAX_TRACE_WORDS);
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

    // Header word positions
    localparam logic [POS_W-1:0] W_ID      = 12'd0;
    localparam logic [POS_W-1:0] W_TS_LOW  = 12'd1;
    localparam logic [POS_W-1:0] W_TYPE    = 12'd2;
    localparam logic [POS_W-1:0] W_FLAGS   = 12'd3;
    localparam logic [POS_W-1:0] W_DISC    = 12'd4;
    localparam logic [POS_W-1:0] W_BASE    = 12'd5;
    localparam logic [POS_W-1:0] W_CFD     = 12'd6;
    localparam logic [POS_W-1:0] W_PRE_E   = 12'd7;
    localparam logic [POS_W-1:0] W_POST_E  = 12'd8;
    localparam logic [POS_W-1:0] W_PEAK_TS = 12'd9;
    localparam logic [POS_W-1:0] W_M1      = 12'd10;
    localparam logic [POS_W-1:0] W_M2      = 12'd11;

    logic [POS_W-1:0]  word_position_reg, word_position_next;
    logic [3:0]        header_kind_reg, header_kind_next;
    logic [31:0]       stamp_low_half_reg, stamp_low_half_next;
    logic [15:0]       flags_word_upper_reg, flags_word_upper_next;
    logic [7:0]        energy_upper_byte_reg, energy_upper_byte_next;
    logic [15:0]       peak_stamp_low_reg, peak_stamp_low_next;
    logic [31:0]       held_trace_word_reg, held_trace_word_next;
    logic              held_trace_valid_reg, held_trace_valid_next;

    logic [WORD_W-1:0] w;
    logic              cfd;
    logic [11:0]       board;
    logic [15:0]       comb_id;
    logic [14:0]       mark_sum;
    logic [POS_W-1:0]  trace_idx;
    logic [POS_W-1:0]  trace_words;

    assign w         = swap_bytes(raw_word);
    assign cfd       = (header_kind_reg == HDR_CFD);
    assign board     = w[15:4];
    assign comb_id   = 16'({board, 3'b000}) + 16'({board, 1'b0}) + 16'(w[3:0]);
    assign mark_sum  = 15'(w[13:0]) + 15'(w[29:16]);
    assign trace_idx = word_position_reg - HDR_WORDS - 12'd1;

    // Trace words seen so far, clamped to the trace limit
    always_comb
    begin
        trace_words = (word_position_reg > HDR_WORDS) ? word_position_reg - HDR_WORDS
                                                      : '0;
        if (trace_words > MAX_TRACE)
            trace_words = MAX_TRACE;
    end

    // Result list and next state
    always_comb
    begin
        logic [COUNT_W-1:0] n;
        n = '0;
        run.ent = '0;

        word_position_next     = word_position_reg;
        header_kind_next       = header_kind_reg;
        stamp_low_half_next    = stamp_low_half_reg;
        flags_word_upper_next  = flags_word_upper_reg;
        energy_upper_byte_next = energy_upper_byte_reg;
        peak_stamp_low_next    = peak_stamp_low_reg;
        held_trace_word_next   = held_trace_word_reg;
        held_trace_valid_next  = 1'b0;

        // previous trace word is now known not to be the last one
        if (held_trace_valid_reg && word_position_reg > HDR_WORDS)
        begin
            run.ent[0] = mk_entry(TAG_TRACE, 48'(held_trace_word_reg[15:0]),
                                  {trace_idx[SAMPLE_W-2:0], 1'b0});
            run.ent[1] = mk_entry(TAG_TRACE, 48'(held_trace_word_reg[31:16]),
                                  {trace_idx[SAMPLE_W-2:0], 1'b1});
            n = 3'd2;
        end

        if (word_position_reg < HDR_WORDS)
        begin
            case (word_position_reg)
                W_ID:
                begin
                    if (!eoe)
                    begin
                        run.ent[0] = mk_entry(TAG_CHAN, 48'(w[3:0]), '0);
                        run.ent[1] = mk_entry(TAG_BOARD, 48'(board), '0);
                        run.ent[2] = mk_entry(TAG_ID, 48'(comb_id), '0);
                        run.ent[3] = mk_entry(TAG_PKT_LEN, 48'(w[26:16]), '0);
                        run.ent[4] = mk_entry(TAG_GEO, 48'(w[31:27]), '0);
                        n = 3'd5;
                    end
                end
                W_TS_LOW:
                begin
                    stamp_low_half_next = w;
                end
                W_TYPE:
                begin
                    header_kind_next = w[19:16];
                    run.ent[0] = mk_entry(TAG_HDR_TYPE, 48'(w[19:16]), '0);
                    run.ent[1] = mk_entry(TAG_EVT_TYPE, 48'(w[25:23]), '0);
                    run.ent[2] = mk_entry(TAG_HDR_LEN, 48'(w[31:26]), '0);
                    run.ent[3] = mk_entry(TAG_TIMESTAMP, {w[15:0], stamp_low_half_reg}, '0);
                    n = 3'd4;
                end
                W_FLAGS:
                begin
                    flags_word_upper_next = w[31:16];
                    run.ent[0] = mk_entry(TAG_FLAGS,
                                          48'(w[15:0] & flag_mask(header_kind_reg)), '0);
                    n = 3'd1;
                end
                W_DISC:
                begin
                    run.ent[0] = mk_entry(TAG_LAST_DISC, {w, flags_word_upper_reg}, '0);
                    run.ent[1] = mk_entry(TAG_CFD0, cfd ? 48'(w[29:16]) : '0, '0);
                    n = 3'd2;
                end
                W_BASE:
                begin
                    run.ent[0] = mk_entry(TAG_SAMPLED_BL, 48'(w[23:0]), '0);
                    n = 3'd1;
                end
                W_CFD:
                begin
                    run.ent[0] = mk_entry(TAG_CFD1, cfd ? 48'(w[13:0]) : '0, '0);
                    run.ent[1] = mk_entry(TAG_CFD2, cfd ? 48'(w[29:16]) : '0, '0);
                    n = 3'd2;
                end
                W_PRE_E:
                begin
                    energy_upper_byte_next = w[31:24];
                    run.ent[0] = mk_entry(TAG_PRE_ENERGY, 48'(w[23:0]), '0);
                    n = 3'd1;
                end
                W_POST_E:
                begin
                    peak_stamp_low_next = w[31:16];
                    run.ent[0] = mk_entry(TAG_POST_ENERGY,
                                          48'({w[15:0], energy_upper_byte_reg}), '0);
                    n = 3'd1;
                end
                W_PEAK_TS:
                begin
                    run.ent[0] = mk_entry(TAG_PEAK_TS, {w, peak_stamp_low_reg}, '0);
                    n = 3'd1;
                end
                W_M1:
                begin
                    run.ent[0] = mk_entry(TAG_M1_BEGIN, 48'(w[13:0]), '0);
                    run.ent[1] = mk_entry(TAG_M1_END, 48'(w[29:16]), '0);
                    run.ent[2] = mk_entry(TAG_BASELINE, 48'(mark_sum[14:1]), '0);
                    n = 3'd3;
                end
                W_M2:
                begin
                    run.ent[0] = mk_entry(TAG_M2_BEGIN, 48'(w[13:0]), '0);
                    run.ent[1] = mk_entry(TAG_M2_END, 48'(w[29:16]), '0);
                    n = 3'd2;
                end
                default:
                begin
                    run.ent[0] = mk_entry(TAG_PEAK_SAMPLE, 48'(w[13:0]), '0);
                    run.ent[1] = mk_entry(TAG_BASE_SAMPLE, 48'(w[29:16]), '0);
                    n = 3'd2;
                end
            endcase
        end
        else if (!eoe && word_position_reg < TRACE_END)
        begin
            held_trace_word_next  = w;
            held_trace_valid_next = 1'b1;
        end

        // close the event, or move on to the next word
        if (eoe)
        begin
            run.ent[n] = mk_entry(TAG_END, 48'({trace_words, 1'b0}), '0);
            n = n + 3'd1;
            word_position_next     = '0;
            header_kind_next       = '0;
            stamp_low_half_next    = '0;
            flags_word_upper_next  = '0;
            energy_upper_byte_next = '0;
            peak_stamp_low_next    = '0;
            held_trace_word_next   = '0;
            held_trace_valid_next  = 1'b0;
        end
        else if (word_position_reg < POS_MAX)
        begin
            word_position_next = word_position_reg + 12'd1;
        end

        run.count = n;
    end

    // Per-event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_position_reg     <= '0;
            header_kind_reg       <= '0;
            stamp_low_half_reg    <= '0;
            flags_word_upper_reg  <= '0;
            energy_upper_byte_reg <= '0;
            peak_stamp_low_reg    <= '0;
            held_trace_word_reg   <= '0;
            held_trace_valid_reg  <= 1'b0;
        end
        else if (step)
        begin
            word_position_reg     <= word_position_next;
            header_kind_reg       <= header_kind_next;
            stamp_low_half_reg    <= stamp_low_half_next;
            flags_word_upper_reg  <= flags_word_upper_next;
            energy_upper_byte_reg <= energy_upper_byte_next;
            peak_stamp_low_reg    <= peak_stamp_low_next;
            held_trace_word_reg   <= held_trace_word_next;
            held_trace_valid_reg  <= held_trace_valid_next;
        end
    end

endmodule

/* hdl/dehd_emit.sv */
// ----------------------------------------------------------------------------
// dehd_emit
// Result register: holds the results of one item and hands them out one per
// accepted output cycle. Reloads on the cycle its last result is taken.
// ----------------------------------------------------------------------------
module dehd_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  dehd_pkg::run_t                 run_in,
    output logic                           free,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dehd_pkg::TAG_W-1:0]     field_tag,
    output logic [dehd_pkg::VALUE_W-1:0]   field_value,
    output logic [dehd_pkg::SAMPLE_W-1:0]  sample_position,
    output logic                           last_of_run
);
    import dehd_pkg::*;

    run_t               run_reg;
    logic               run_valid_reg;
    logic [COUNT_W-1:0] idx_reg;
    entry_t             cur;
    logic               take;

    assign cur  = run_reg.ent[idx_reg];
    assign take = run_valid_reg && !out_stall;

    assign out_valid       = run_valid_reg;
    assign field_tag       = TAG_W'(cur.tag);
    assign field_value     = cur.value;
    assign sample_position = cur.pos;
    assign last_of_run     = (idx_reg == run_reg.count - 3'd1);

    // room for the next item's results
    assign free = !run_valid_reg || (take && last_of_run);

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
            run_reg <= run_in;
    end

    // Result sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            run_valid_reg <= (run_in.count != '0);
            idx_reg       <= '0;
        end
        else if (take)
        begin
            if (last_of_run)
                run_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

/* hdl/digitizer_event_header_decoder.sv */
// An accepted item passes through the input register and then the result
// register before its first result reaches the outputs. The single result port
// drains the result register one result at a time; a waiting item is loaded
// as its last result is taken. An item that causes no result leaves it empty.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// per-event state to the start of an event.
// ----------------------------------------------------------------------------
// digitizer_event_header_decoder
// Byte-swaps digitizer event words, decodes the 13 header words into tagged
// fields and splits trace words into pairs of 16-bit samples.
// ----------------------------------------------------------------------------
module digitizer_event_header_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dehd_pkg::WORD_W-1:0]    event_word,
    input  logic                           end_of_event,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dehd_pkg::TAG_W-1:0]     field_tag,
    output logic [dehd_pkg::VALUE_W-1:0]   field_value,
    output logic [dehd_pkg::SAMPLE_W-1:0]  sample_position,
    output logic                           last_of_run
);
    import dehd_pkg::*;

    logic              in_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic              eoe_reg;
    logic              free;
    logic              consume;
    run_t              run;

    assign consume  = in_valid_reg && free;
    assign in_stall = in_valid_reg && !free;

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= event_word;
            eoe_reg  <= end_of_event;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    dehd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (consume),
        .raw_word (word_reg),
        .eoe      (eoe_reg),
        .run      (run)
    );

    dehd_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (consume),
        .run_in          (run),
        .free            (free),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .field_tag       (field_tag),
        .field_value     (field_value),
        .sample_position (sample_position),
        .last_of_run     (last_of_run)
    );

    // Only trace samples carry a sample position
    a_pos_trace_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_tag != TAG_TRACE |-> sample_position == '0)
        else $error("sample position set on a non-trace result");

    // The end-of-event result closes its item's run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_tag == TAG_END |-> last_of_run)
        else $error("end-of-event result is not last of its run");

    // Taking the last result with nothing to reload empties the output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_of_run && !consume |=> !out_valid)
        else $error("output still valid after its last result was taken");

endmodule
